// ----- hw/rtl/rbs_pkg.sv -----
// Shared types and constants for the ray/box slab intersection block.
// No dependencies.
`timescale 1ns / 1ps

package rbs_pkg;

    localparam int COORD_W  = 32;
    localparam int AXES     = 3;
    localparam int PLANES   = 2 * AXES;
    localparam int THRESH_W = 17;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [THRESH_W-1:0] thresh_t;

    localparam coord_t DIST_MAX = 32'sh7FFF_FFFF;
    localparam coord_t DIST_MIN = 32'sh8000_0000;

    // Per-item control carried alongside the data through the pipeline.
    typedef struct packed {
        logic [PLANES-1:0] neg;    // quotient sign per plane
        logic [AXES-1:0]   par;    // axis counts as parallel
        logic              pmiss;  // parallel axis with origin outside slab
    } side_t;

endpackage

// ----- hw/rtl/rbs_udiv.sv -----
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Uses no package; its stages advance only while en is high.
`timescale 1ns / 1ps

module rbs_udiv #(
    parameter int NUM_W = 49,
    parameter int DEN_W = 32
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo
);

    logic [DEN_W-1:0] rem_reg [NUM_W];
    logic [NUM_W-1:0] nq_reg  [NUM_W];
    logic [DEN_W-1:0] den_reg [NUM_W];

    logic [DEN_W-1:0] rem_in   [NUM_W];
    logic [NUM_W-1:0] nq_in    [NUM_W];
    logic [DEN_W-1:0] den_in   [NUM_W];
    logic [DEN_W:0]   trial    [NUM_W];
    logic             ge       [NUM_W];
    logic [DEN_W-1:0] rem_next [NUM_W];
    logic [NUM_W-1:0] nq_next  [NUM_W];

    always_comb begin
        for (int k = 0; k < NUM_W; k++) begin
            if (k == 0) begin
                rem_in[k] = '0;
                nq_in[k]  = num;
                den_in[k] = den;
            end else begin
                rem_in[k] = rem_reg[k-1];
                nq_in[k]  = nq_reg[k-1];
                den_in[k] = den_reg[k-1];
            end
            trial[k] = {rem_in[k], nq_in[k][NUM_W-1]};
            ge[k]    = trial[k] >= {1'b0, den_in[k]};
            rem_next[k] = ge[k] ? DEN_W'(trial[k] - {1'b0, den_in[k]})
                                : trial[k][DEN_W-1:0];
            nq_next[k]  = {nq_in[k][NUM_W-2:0], ge[k]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NUM_W; k++) begin
                rem_reg[k] <= rem_next[k];
                nq_reg[k]  <= nq_next[k];
                den_reg[k] <= den_in[k];
            end
        end
    end

    assign quo = nq_reg[NUM_W-1];

endmodule

// ----- hw/rtl/ray_box_slab_intersect.sv -----
// Top level of the ray versus axis-aligned box slab test, Q16.16 fixed point.
// Depends on rbs_pkg and rbs_udiv.
//
//   channel  dir  handshake          payload
//   s_       in   s_tvalid/tready    s_tdata[383:0]: 12 coordinates, 32 bits each
//   m_       out  m_tvalid/tready    m_tdata[71:0]: hit, t_near, t_far
//   cfg_     in   cfg_wr_en          cfg_wr_data[16:0]: parallel_threshold
//
// One item per cycle while the output is not stalled; the quotient pipeline
// computes one bit per stage. All stages advance together; a stalled output
// holds the whole pipeline and s_tready drops. Synchronous active-low reset
// clears the valid bits and sets the threshold to 7.
`timescale 1ns / 1ps

module ray_box_slab_intersect #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  rbs_pkg::thresh_t      cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // box_min_x, box_max_x, box_min_y, box_max_y, box_min_z, box_max_z,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (32 bits each)
    input  logic [383:0]          s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // hit [0], t_near [32:1], t_far [64:33], zero [71:65]
    output logic [71:0]           m_tdata
);

    import rbs_pkg::*;

    localparam int MAG_W = COORD_W + 1;
    localparam int NUM_W = MAG_W + FRAC_BITS;
    localparam logic [NUM_W-1:0] POS_LIM = NUM_W'(32'h7FFF_FFFF);
    localparam logic [NUM_W-1:0] NEG_LIM = NUM_W'(32'h8000_0000);

    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    thresh_t thresh_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= THRESH_W'(7);
        end else if (cfg_wr_en) begin
            thresh_reg <= cfg_wr_data;
        end
    end

    // Stage 0: input register
    logic   v0_reg;
    coord_t in_reg [12];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= s_tvalid;
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 12; i++) begin
                in_reg[i] <= s_tdata[32*i +: 32];
            end
        end
    end

    // Stage 1: differences, magnitudes, parallel test
    logic signed [MAG_W-1:0] diff    [PLANES];
    logic [MAG_W-1:0]        dmag    [PLANES];
    logic [NUM_W-1:0]        num_nx  [PLANES];
    logic [COORD_W-1:0]      den_nx  [AXES];
    side_t                   side_nx;
    coord_t                  lo_c, hi_c, org_c, dir_c;

    always_comb begin
        side_nx = '0;
        lo_c  = '0;
        hi_c  = '0;
        org_c = '0;
        dir_c = '0;
        for (int a = 0; a < AXES; a++) begin
            lo_c  = in_reg[2*a];
            hi_c  = in_reg[2*a+1];
            org_c = in_reg[6+a];
            dir_c = in_reg[9+a];
            diff[2*a]   = {lo_c[COORD_W-1], lo_c} - {org_c[COORD_W-1], org_c};
            diff[2*a+1] = {hi_c[COORD_W-1], hi_c} - {org_c[COORD_W-1], org_c};
            den_nx[a] = dir_c[COORD_W-1] ? COORD_W'(-dir_c) : COORD_W'(dir_c);
            side_nx.par[a] = (dir_c == '0) ||
                             (den_nx[a] < {{(COORD_W-THRESH_W){1'b0}}, thresh_reg});
            if (side_nx.par[a] && ((org_c < lo_c) || (org_c > hi_c))) begin
                side_nx.pmiss = 1'b1;
            end
            for (int j = 0; j < 2; j++) begin
                dmag[2*a+j] = diff[2*a+j][MAG_W-1] ? MAG_W'(-diff[2*a+j])
                                                   : MAG_W'(diff[2*a+j]);
                num_nx[2*a+j] = {dmag[2*a+j], {FRAC_BITS{1'b0}}};
                side_nx.neg[2*a+j] = diff[2*a+j][MAG_W-1] ^ dir_c[COORD_W-1];
            end
        end
    end

    logic               v1_reg;
    side_t              side1_reg;
    logic [NUM_W-1:0]   num_reg [PLANES];
    logic [COORD_W-1:0] den_reg [AXES];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= v0_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            side1_reg <= side_nx;
            num_reg   <= num_nx;
            den_reg   <= den_nx;
        end
    end

    // Quotient pipeline
    logic [NUM_W-1:0] quo [PLANES];
    for (genvar p = 0; p < PLANES; p++) begin : g_div
        rbs_udiv #(
            .NUM_W(NUM_W),
            .DEN_W(COORD_W)
        ) u_div (
            .aclk(aclk),
            .en  (adv),
            .num (num_reg[p]),
            .den (den_reg[p/2]),
            .quo (quo[p])
        );
    end

    logic  vd_reg    [NUM_W];
    side_t sided_reg [NUM_W];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_W; k++) begin
                vd_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            vd_reg[0] <= v1_reg;
            for (int k = 1; k < NUM_W; k++) begin
                vd_reg[k] <= vd_reg[k-1];
            end
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            sided_reg[0] <= side1_reg;
            for (int k = 1; k < NUM_W; k++) begin
                sided_reg[k] <= sided_reg[k-1];
            end
        end
    end

    // Stage 2: sign and saturate
    coord_t sat_nx [PLANES];
    always_comb begin
        for (int p = 0; p < PLANES; p++) begin
            if (sided_reg[NUM_W-1].neg[p]) begin
                sat_nx[p] = (quo[p] > NEG_LIM) ? DIST_MIN : COORD_W'(-quo[p]);
            end else begin
                sat_nx[p] = (quo[p] > POS_LIM) ? DIST_MAX : COORD_W'(quo[p]);
            end
        end
    end

    logic   v2_reg;
    side_t  side2_reg;
    coord_t sat_reg [PLANES];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= vd_reg[NUM_W-1];
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            side2_reg <= sided_reg[NUM_W-1];
            sat_reg   <= sat_nx;
        end
    end

    // Stage 3: order the two plane distances of each axis
    logic   v3_reg;
    side_t  side3_reg;
    coord_t tlo_reg [AXES];
    coord_t thi_reg [AXES];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= v2_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            side3_reg <= side2_reg;
            for (int a = 0; a < AXES; a++) begin
                if (sat_reg[2*a] > sat_reg[2*a+1]) begin
                    tlo_reg[a] <= sat_reg[2*a+1];
                    thi_reg[a] <= sat_reg[2*a];
                end else begin
                    tlo_reg[a] <= sat_reg[2*a];
                    thi_reg[a] <= sat_reg[2*a+1];
                end
            end
        end
    end

    // Stage 4: fold into near maximum and far minimum
    coord_t near_nx, far_nx;
    always_comb begin
        near_nx = DIST_MIN;
        far_nx  = DIST_MAX;
        for (int a = 0; a < AXES; a++) begin
            if (!side3_reg.par[a]) begin
                if (tlo_reg[a] > near_nx) near_nx = tlo_reg[a];
                if (thi_reg[a] < far_nx)  far_nx  = thi_reg[a];
            end
        end
    end

    logic   v4_reg;
    logic   pmiss4_reg;
    coord_t near_reg, far_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (adv) begin
            v4_reg <= v3_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            pmiss4_reg <= side3_reg.pmiss;
            near_reg   <= near_nx;
            far_reg    <= far_nx;
        end
    end

    // Stage 5: hit decision and output register
    logic   hit_nx;
    logic   m_valid_reg;
    logic   hit_reg;
    coord_t tn_reg, tf_reg;
    assign hit_nx = !pmiss4_reg && !(far_reg < near_reg) && !(far_reg < 0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= v4_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            hit_reg <= hit_nx;
            tn_reg  <= hit_nx ? near_reg : '0;
            tf_reg  <= hit_nx ? far_reg  : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, tf_reg, tn_reg, hit_reg};

`ifndef SYNTHESIS
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[64:1] == '0))
        else $error("miss item carries nonzero distances");

    a_hit_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> (!tf_reg[COORD_W-1] && (tf_reg >= tn_reg)))
        else $error("hit item with far below near or below zero");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready out of step with output stall");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> ($stable(v4_reg) && $stable(vd_reg[NUM_W-1]) && $stable(near_reg)))
        else $error("pipeline moved during stall");
`endif

endmodule
